>>> rtl/core/sync_len_cobs_crc_frame_receiver_defines.svh
// Assertion helpers shared by the frame receiver RTL.
`ifndef SYNC_LEN_COBS_CRC_FRAME_RECEIVER_DEFINES_SVH
`define SYNC_LEN_COBS_CRC_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SLCCFR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame receiver assertion failed");

// Next-cycle implication, checked outside reset.
`define SLCCFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame receiver assertion failed");

`endif

>>> rtl/core/slccfr_pkg.sv
package slccfr_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [7:0] SYNC_FIRST_RESET  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'h55;
   localparam logic [7:0] COBS_MAX_CODE     = 8'hFF;

   localparam int unsigned LEN_WIDTH = 14;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [1:0] CSR_MAX_BODY    = 2'd2;

   // Frame status codes carried on the end-of-frame word.
   localparam logic [1:0] STATUS_GOOD      = 2'd0;
   localparam logic [1:0] STATUS_CRC_ERROR = 2'd1;
   localparam logic [1:0] STATUS_COBS_ERROR = 2'd2;
   localparam logic [1:0] STATUS_EMPTY     = 2'd3;

   typedef enum logic [6:0] {
      PH_SYNC0 = 7'b0000001,
      PH_SYNC1 = 7'b0000010,
      PH_LENLO = 7'b0000100,
      PH_LENHI = 7'b0001000,
      PH_BODY  = 7'b0010000,
      PH_CRCLO = 7'b0100000,
      PH_CRCHI = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [7:0]           sync_first;
      logic [7:0]           sync_second;
      logic [LEN_WIDTH-1:0] max_body_length;
   } cfg_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       end_of_frame;
      logic [1:0] frame_status;
   } rsp_item_type;

endpackage

>>> rtl/core/slccfr_crc16.sv
module slccfr_crc16
   import slccfr_pkg::*;
(
   input  logic [15:0] crc_cur,
   input  logic [7:0]  data,
   output logic [15:0] crc_next
);

   // CRC-16/CCITT-FALSE, MSB first, one byte per call.
   always_comb begin
      logic [15:0] crc;
      crc = crc_cur ^ {data, 8'h00};
      for (int n = 0; n < 8; n++) begin
         if (crc[15]) begin
            crc = {crc[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc = {crc[14:0], 1'b0};
         end
      end
      crc_next = crc;
   end

endmodule

>>> rtl/core/slccfr_parser.sv
module slccfr_parser
   import slccfr_pkg::*;
#(
   parameter int unsigned MAX_BODY = 8192
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [7:0]   rx_byte,
   input  cfg_type      cfg,
   output logic         result_valid,
   output rsp_item_type result
);

   phase_type            phase_ff, phase_in;
   logic [LEN_WIDTH-1:0] body_length_ff, body_length_in;
   logic [LEN_WIDTH-1:0] byte_count_ff, byte_count_in;
   logic [15:0]          crc_ff, crc_in;
   logic [7:0]           crc_low_ff, crc_low_in;
   logic [7:0]           group_left_ff, group_left_in;
   logic                 zero_pending_ff, zero_pending_in;
   logic                 decode_error_ff, decode_error_in;
   logic                 payload_seen_ff, payload_seen_in;

   logic [15:0] crc_next;
   logic [15:0] full_len;
   logic        len_bad;

   slccfr_crc16 u_crc (
      .crc_cur  (crc_ff),
      .data     (rx_byte),
      .crc_next (crc_next)
   );

   assign full_len = {rx_byte, body_length_ff[7:0]};
   assign len_bad  = (full_len == 16'd0)
                  || (full_len > {2'b00, cfg.max_body_length})
                  || (full_len > 16'(MAX_BODY));

   always_comb begin
      phase_in        = phase_ff;
      body_length_in  = body_length_ff;
      byte_count_in   = byte_count_ff;
      crc_in          = crc_ff;
      crc_low_in      = crc_low_ff;
      group_left_in   = group_left_ff;
      zero_pending_in = zero_pending_ff;
      decode_error_in = decode_error_ff;
      payload_seen_in = payload_seen_ff;
      result_valid    = 1'b0;
      result          = '0;

      unique case (phase_ff)
         PH_SYNC1: begin
            phase_in = (rx_byte == cfg.sync_second) ? PH_LENLO : PH_SYNC0;
         end
         PH_LENLO: begin
            body_length_in = {{(LEN_WIDTH-8){1'b0}}, rx_byte};
            phase_in       = PH_LENHI;
         end
         PH_LENHI: begin
            body_length_in = full_len[LEN_WIDTH-1:0];
            if (len_bad) begin
               phase_in = PH_SYNC0;
            end else begin
               byte_count_in   = '0;
               crc_in          = CRC_INIT;
               group_left_in   = 8'd0;
               zero_pending_in = 1'b0;
               decode_error_in = 1'b0;
               payload_seen_in = 1'b0;
               phase_in        = PH_BODY;
            end
         end
         PH_BODY: begin
            crc_in = crc_next;
            if (!decode_error_ff) begin
               if (group_left_ff == 8'd0) begin
                  if (rx_byte == 8'd0) begin
                     decode_error_in = 1'b1;
                  end else begin
                     // A new code byte releases the previous group's zero.
                     if (zero_pending_ff) begin
                        result_valid    = 1'b1;
                        payload_seen_in = 1'b1;
                     end
                     group_left_in   = rx_byte - 8'd1;
                     zero_pending_in = (rx_byte != COBS_MAX_CODE);
                  end
               end else begin
                  group_left_in       = group_left_ff - 8'd1;
                  result_valid        = 1'b1;
                  result.payload_byte = rx_byte;
                  payload_seen_in     = 1'b1;
               end
            end
            byte_count_in = byte_count_ff + 1'b1;
            if (byte_count_in >= body_length_ff) begin
               phase_in = PH_CRCLO;
            end
         end
         PH_CRCLO: begin
            crc_low_in = rx_byte;
            phase_in   = PH_CRCHI;
         end
         PH_CRCHI: begin
            result_valid        = 1'b1;
            result.end_of_frame = 1'b1;
            if ({rx_byte, crc_low_ff} != crc_ff) begin
               result.frame_status = STATUS_CRC_ERROR;
            end else if (decode_error_ff || (group_left_ff != 8'd0)) begin
               result.frame_status = STATUS_COBS_ERROR;
            end else if (!payload_seen_ff) begin
               result.frame_status = STATUS_EMPTY;
            end else begin
               result.frame_status = STATUS_GOOD;
            end
            phase_in = PH_SYNC0;
         end
         default: begin
            phase_in = (rx_byte == cfg.sync_first) ? PH_SYNC1 : PH_SYNC0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_SYNC0;
         body_length_ff  <= '0;
         byte_count_ff   <= '0;
         crc_ff          <= CRC_INIT;
         crc_low_ff      <= 8'd0;
         group_left_ff   <= 8'd0;
         zero_pending_ff <= 1'b0;
         decode_error_ff <= 1'b0;
         payload_seen_ff <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         body_length_ff  <= body_length_in;
         byte_count_ff   <= byte_count_in;
         crc_ff          <= crc_in;
         crc_low_ff      <= crc_low_in;
         group_left_ff   <= group_left_in;
         zero_pending_ff <= zero_pending_in;
         decode_error_ff <= decode_error_in;
         payload_seen_ff <= payload_seen_in;
      end
   end

endmodule

>>> rtl/core/slccfr_rsp_stage.sv
module slccfr_rsp_stage
   import slccfr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type load_item,
   output logic         can_load,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   // The register may be refilled in the same cycle its word is taken.
   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

>>> rtl/core/sync_len_cobs_crc_frame_receiver.sv
// A received word waits in the input register; its result, if any, is then loaded into the
// result register, from which the consumer takes it. Throughput: one received word per cycle
// while results drain; the parser steps once per word in the input register. Rate is set by
// the combinational CRC byte update and COBS step between the two registers.
// Reset (synchronous, active high) restores the sync bytes AA/55, the length limit
// MAX_BODY, the hunt for the first sync byte, and empties both registers.
`include "sync_len_cobs_crc_frame_receiver_defines.svh"

module sync_len_cobs_crc_frame_receiver
   import slccfr_pkg::*;
#(
   parameter int unsigned MAX_BODY = 8192
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_payload_byte,
   output logic                 rsp_end_of_frame,
   output logic [1:0]           rsp_frame_status,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [LEN_WIDTH-1:0] csr_wdata
);

   // Configuration registers. Writes must arrive only while the receiver is idle; unchecked.
   cfg_type cfg_ff;

   // Input register: one received word waits here for the parser.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   logic         step;
   logic         can_load;
   logic         result_valid;
   rsp_item_type result;
   rsp_item_type rsp_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first      <= SYNC_FIRST_RESET;
         cfg_ff.sync_second     <= SYNC_SECOND_RESET;
         cfg_ff.max_body_length <= LEN_WIDTH'(MAX_BODY);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SYNC_FIRST:  cfg_ff.sync_first      <= csr_wdata[7:0];
            CSR_SYNC_SECOND: cfg_ff.sync_second     <= csr_wdata[7:0];
            CSR_MAX_BODY:    cfg_ff.max_body_length <= csr_wdata;
            default: begin
               // Writes to an unassigned index are dropped.
            end
         endcase
      end
   end

   // The parser steps whenever a word is held and the result register can
   // take whatever that word produces. Every word steps the parser, whether
   // or not it yields a result, so holding back on a full result register is
   // enough to keep results in order.
   assign step      = in_valid_ff && can_load;
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   slccfr_parser #(
      .MAX_BODY (MAX_BODY)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .rx_byte      (in_byte_ff),
      .cfg          (cfg_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   slccfr_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (step && result_valid),
      .load_item (result),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_payload_byte = rsp_item.payload_byte;
   assign rsp_end_of_frame = rsp_item.end_of_frame;
   assign rsp_frame_status = rsp_item.frame_status;

   // An end-of-frame word never carries payload data.
   `SLCCFR_ASSERT_IMPL(a_eof_no_data, clock, reset,
      rsp_valid && rsp_end_of_frame, rsp_payload_byte == 8'd0)
   // Payload words always carry the good status code.
   `SLCCFR_ASSERT_IMPL(a_data_status_clear, clock, reset,
      rsp_valid && !rsp_end_of_frame, rsp_frame_status == STATUS_GOOD)
   // A held word that cannot step stays in the input register.
   `SLCCFR_ASSERT_NEXT(a_in_hold, clock, reset,
      in_valid_ff && !step, in_valid_ff && (in_byte_ff == $past(in_byte_ff)))
   // A step that yields a result shows it on the next cycle.
   `SLCCFR_ASSERT_NEXT(a_result_shown, clock, reset,
      step && result_valid, rsp_valid)

endmodule
